// ----- design/ctp_pkg.sv -----
// ============================================================================
// ctp_pkg - circle through three points, shared types and widths
// Most pipeline word widths follow from the coordinate width; RESW and MAGW are fixed.
// ============================================================================
`default_nettype none

package ctp_pkg;

    // coordinate width of one input field
    localparam int CW    = 24;
    // point offsets from the first point
    localparam int DW    = CW + 1;
    // products of two offsets, signed
    localparam int PW    = 2 * DW;
    // twice the signed triangle area
    localparam int DETW  = PW + 1;
    // sum of two squared offsets, non-negative
    localparam int SW    = PW;
    // upper part of a squared sum, split for the multipliers
    localparam int HW    = SW - DW;
    // offset times one half of a squared sum
    localparam int PPW   = 2 * DW + 1;
    // centre numerators
    localparam int NW    = PPW + DW + 1;
    // divider dividend, divisor and quotient
    localparam int NUMW  = NW + 1;
    localparam int DENW  = DETW + 2;
    localparam int REMW  = DENW;
    localparam int QW    = NUMW;
    // signed centre offset and centre before saturation
    localparam int OW    = NUMW + 1;
    localparam int CXW   = OW + 1;
    // result width
    localparam int RESW  = 32;
    // offset magnitudes that take part in the radius
    localparam int MAGW  = 33;
    // square root operand, root and partial remainder
    localparam int SQW   = 2 * MAGW + 2;
    localparam int ROOTW = SQW / 2;
    localparam int SRW   = ROOTW + 2;

    typedef struct packed {
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] middle_x;
        logic signed [CW-1:0] middle_y;
        logic signed [CW-1:0] last_x;
        logic signed [CW-1:0] last_y;
    } points_t;

    typedef struct packed {
        logic                   circle_valid;
        logic signed [RESW-1:0] centre_x;
        logic signed [RESW-1:0] centre_y;
        logic        [RESW-1:0] radius;
    } circle_t;

    // travels alongside the divider stages
    typedef struct packed {
        logic                 ok;
        logic                 negx;
        logic                 negy;
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
    } div_side_t;

    // travels alongside the square root stages
    typedef struct packed {
        logic            ok;
        logic            big;
        logic [RESW-1:0] cx;
        logic [RESW-1:0] cy;
    } sqrt_side_t;

endpackage

`default_nettype wire

// ----- design/circle_through_three_points_top.sv -----
// ============================================================================
// circle_through_three_points_top - circumcircle of three planar points
// Exact fixed point centre (rounded, saturated) and floor square root radius.
// ============================================================================
//
//  channel | handshake              | payload            | role
//  --------+------------------------+--------------------+------------------
//  pts     | pts_valid / pts_stall  | ctp_pkg::points_t  | point triple in
//  circ    | circ_valid / circ_stall| ctp_pkg::circle_t  | circle result out
//
//  One transaction enters per cycle while pts_stall is low. Depth is set by
//  the restoring divider (one quotient bit per stage, 78 stages) and the
//  digit-by-digit square root (34 stages).
//  Reset clears all valid bits, including those of the output and skid
//  registers. A stall on circ parks one result in the skid register and
//  freezes the whole pipeline the following cycle; pts_stall is that skid flag.
//
`default_nettype none

module circle_through_three_points_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pts_valid,
    output logic                  pts_stall,
    input  wire ctp_pkg::points_t pts,
    output logic                  circ_valid,
    input  wire logic             circ_stall,
    output ctp_pkg::circle_t      circ
);

    localparam int DW    = ctp_pkg::DW;
    localparam int CW    = ctp_pkg::CW;
    localparam int PW    = ctp_pkg::PW;
    localparam int DETW  = ctp_pkg::DETW;
    localparam int SW    = ctp_pkg::SW;
    localparam int HW    = ctp_pkg::HW;
    localparam int PPW   = ctp_pkg::PPW;
    localparam int NW    = ctp_pkg::NW;
    localparam int NUMW  = ctp_pkg::NUMW;
    localparam int DENW  = ctp_pkg::DENW;
    localparam int REMW  = ctp_pkg::REMW;
    localparam int QW    = ctp_pkg::QW;
    localparam int OW    = ctp_pkg::OW;
    localparam int CXW   = ctp_pkg::CXW;
    localparam int RESW  = ctp_pkg::RESW;
    localparam int MAGW  = ctp_pkg::MAGW;
    localparam int SQW   = ctp_pkg::SQW;
    localparam int ROOTW = ctp_pkg::ROOTW;
    localparam int SRW   = ctp_pkg::SRW;

    // pipeline advance: everything moves unless a result sits in the skid
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en        = !skid_valid_reg;
    assign pts_stall = skid_valid_reg;

    // ------------------------------------------------------------------
    // S1: offsets of middle and last point from the first
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic signed [DW-1:0] s1_u1_reg, s1_v1_reg, s1_u2_reg, s1_v2_reg;
    logic signed [CW-1:0] s1_x0_reg, s1_y0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= pts_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x0_reg <= pts.first_x;
            s1_y0_reg <= pts.first_y;
            s1_u1_reg <= {pts.middle_x[CW-1], pts.middle_x} - {pts.first_x[CW-1], pts.first_x};
            s1_v1_reg <= {pts.middle_y[CW-1], pts.middle_y} - {pts.first_y[CW-1], pts.first_y};
            s1_u2_reg <= {pts.last_x[CW-1], pts.last_x} - {pts.first_x[CW-1], pts.first_x};
            s1_v2_reg <= {pts.last_y[CW-1], pts.last_y} - {pts.first_y[CW-1], pts.first_y};
        end
    end

    // ------------------------------------------------------------------
    // S2: cross products and squares
    // ------------------------------------------------------------------
    logic                 s2_valid_reg;
    logic signed [PW-1:0] s2_puv_reg, s2_pvu_reg;
    logic signed [PW-1:0] s2_qu1_reg, s2_qv1_reg, s2_qu2_reg, s2_qv2_reg;
    logic signed [DW-1:0] s2_u1_reg, s2_v1_reg, s2_u2_reg, s2_v2_reg;
    logic signed [CW-1:0] s2_x0_reg, s2_y0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_puv_reg <= s1_u1_reg * s1_v2_reg;
            s2_pvu_reg <= s1_u2_reg * s1_v1_reg;
            s2_qu1_reg <= s1_u1_reg * s1_u1_reg;
            s2_qv1_reg <= s1_v1_reg * s1_v1_reg;
            s2_qu2_reg <= s1_u2_reg * s1_u2_reg;
            s2_qv2_reg <= s1_v2_reg * s1_v2_reg;
            s2_u1_reg  <= s1_u1_reg;
            s2_v1_reg  <= s1_v1_reg;
            s2_u2_reg  <= s1_u2_reg;
            s2_v2_reg  <= s1_v2_reg;
            s2_x0_reg  <= s1_x0_reg;
            s2_y0_reg  <= s1_y0_reg;
        end
    end

    // ------------------------------------------------------------------
    // S3: doubled area and squared lengths
    // ------------------------------------------------------------------
    logic                   s3_valid_reg;
    logic signed [DETW-1:0] s3_det_reg;
    logic        [SW-1:0]   s3_sq1_reg, s3_sq2_reg;
    logic signed [DW-1:0]   s3_u1_reg, s3_v1_reg, s3_u2_reg, s3_v2_reg;
    logic signed [CW-1:0]   s3_x0_reg, s3_y0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_det_reg <= {s2_puv_reg[PW-1], s2_puv_reg} - {s2_pvu_reg[PW-1], s2_pvu_reg};
            s3_sq1_reg <= $unsigned(s2_qu1_reg) + $unsigned(s2_qv1_reg);
            s3_sq2_reg <= $unsigned(s2_qu2_reg) + $unsigned(s2_qv2_reg);
            s3_u1_reg  <= s2_u1_reg;
            s3_v1_reg  <= s2_v1_reg;
            s3_u2_reg  <= s2_u2_reg;
            s3_v2_reg  <= s2_v2_reg;
            s3_x0_reg  <= s2_x0_reg;
            s3_y0_reg  <= s2_y0_reg;
        end
    end

    // ------------------------------------------------------------------
    // S4: partial products of offsets with halves of the squared lengths
    // ------------------------------------------------------------------
    logic                   s4_valid_reg;
    logic signed [PPW-1:0]  s4_a1h_reg, s4_a1l_reg, s4_a2h_reg, s4_a2l_reg;
    logic signed [PPW-1:0]  s4_b1h_reg, s4_b1l_reg, s4_b2h_reg, s4_b2l_reg;
    logic signed [DETW-1:0] s4_det_reg;
    logic signed [CW-1:0]   s4_x0_reg, s4_y0_reg;
    logic signed [DW:0]     s3_sq1_lo, s3_sq2_lo;
    logic signed [HW:0]     s3_sq1_hi, s3_sq2_hi;

    assign s3_sq1_lo = $signed({1'b0, s3_sq1_reg[DW-1:0]});
    assign s3_sq2_lo = $signed({1'b0, s3_sq2_reg[DW-1:0]});
    assign s3_sq1_hi = $signed({1'b0, s3_sq1_reg[SW-1:DW]});
    assign s3_sq2_hi = $signed({1'b0, s3_sq2_reg[SW-1:DW]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // nx = v2*s1 - v1*s2, ny = u1*s2 - u2*s1
            s4_a1h_reg <= s3_v2_reg * s3_sq1_hi;
            s4_a1l_reg <= s3_v2_reg * s3_sq1_lo;
            s4_a2h_reg <= s3_v1_reg * s3_sq2_hi;
            s4_a2l_reg <= s3_v1_reg * s3_sq2_lo;
            s4_b1h_reg <= s3_u1_reg * s3_sq2_hi;
            s4_b1l_reg <= s3_u1_reg * s3_sq2_lo;
            s4_b2h_reg <= s3_u2_reg * s3_sq1_hi;
            s4_b2l_reg <= s3_u2_reg * s3_sq1_lo;
            s4_det_reg <= s3_det_reg;
            s4_x0_reg  <= s3_x0_reg;
            s4_y0_reg  <= s3_y0_reg;
        end
    end

    // ------------------------------------------------------------------
    // S5: recombine the partial products
    // ------------------------------------------------------------------
    logic                   s5_valid_reg;
    logic signed [NW-1:0]   s5_ta1_reg, s5_ta2_reg, s5_tb1_reg, s5_tb2_reg;
    logic signed [DETW-1:0] s5_det_reg;
    logic signed [CW-1:0]   s5_x0_reg, s5_y0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_ta1_reg <= {s4_a1h_reg[PPW-1], s4_a1h_reg, {DW{1'b0}}}
                        + {{(NW-PPW){s4_a1l_reg[PPW-1]}}, s4_a1l_reg};
            s5_ta2_reg <= {s4_a2h_reg[PPW-1], s4_a2h_reg, {DW{1'b0}}}
                        + {{(NW-PPW){s4_a2l_reg[PPW-1]}}, s4_a2l_reg};
            s5_tb1_reg <= {s4_b1h_reg[PPW-1], s4_b1h_reg, {DW{1'b0}}}
                        + {{(NW-PPW){s4_b1l_reg[PPW-1]}}, s4_b1l_reg};
            s5_tb2_reg <= {s4_b2h_reg[PPW-1], s4_b2h_reg, {DW{1'b0}}}
                        + {{(NW-PPW){s4_b2l_reg[PPW-1]}}, s4_b2l_reg};
            s5_det_reg <= s4_det_reg;
            s5_x0_reg  <= s4_x0_reg;
            s5_y0_reg  <= s4_y0_reg;
        end
    end

    // ------------------------------------------------------------------
    // S6: centre numerators and the degenerate check
    // ------------------------------------------------------------------
    logic                   s6_valid_reg;
    logic signed [NW-1:0]   s6_nx_reg, s6_ny_reg;
    logic signed [DETW-1:0] s6_det_reg;
    logic                   s6_ok_reg;
    logic signed [CW-1:0]   s6_x0_reg, s6_y0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (en)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_nx_reg  <= s5_ta1_reg - s5_ta2_reg;
            s6_ny_reg  <= s5_tb1_reg - s5_tb2_reg;
            s6_det_reg <= s5_det_reg;
            s6_ok_reg  <= (s5_det_reg != '0);
            s6_x0_reg  <= s5_x0_reg;
            s6_y0_reg  <= s5_y0_reg;
        end
    end

    // ------------------------------------------------------------------
    // S7: magnitudes and quotient signs
    // ------------------------------------------------------------------
    logic                s7_valid_reg;
    logic [NW-1:0]       s7_ax_reg, s7_ay_reg;
    logic [DETW-1:0]     s7_dabs_reg;
    ctp_pkg::div_side_t  s7_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_valid_reg <= 1'b0;
        else if (en)
            s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_ax_reg        <= s6_nx_reg[NW-1] ? NW'(-s6_nx_reg) : NW'(s6_nx_reg);
            s7_ay_reg        <= s6_ny_reg[NW-1] ? NW'(-s6_ny_reg) : NW'(s6_ny_reg);
            s7_dabs_reg      <= s6_det_reg[DETW-1] ? DETW'(-s6_det_reg) : DETW'(s6_det_reg);
            s7_side_reg.ok   <= s6_ok_reg;
            s7_side_reg.negx <= s6_nx_reg[NW-1] ^ s6_det_reg[DETW-1];
            s7_side_reg.negy <= s6_ny_reg[NW-1] ^ s6_det_reg[DETW-1];
            s7_side_reg.x0   <= s6_x0_reg;
            s7_side_reg.y0   <= s6_y0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: stage 0 loads (2|n| + 2|det|) / (4|det|), then one quotient bit
    // per stage, restoring, for x and y side by side
    // ------------------------------------------------------------------
    logic               dv_valid_reg [0:QW];
    logic [NUMW-1:0]    dvx_num_reg  [0:QW];
    logic [NUMW-1:0]    dvy_num_reg  [0:QW];
    logic [REMW-1:0]    dvx_rem_reg  [0:QW];
    logic [REMW-1:0]    dvy_rem_reg  [0:QW];
    logic [NUMW-1:0]    dvx_quo_reg  [0:QW];
    logic [NUMW-1:0]    dvy_quo_reg  [0:QW];
    logic [DENW-1:0]    dv_den_reg   [0:QW];
    ctp_pkg::div_side_t dv_side_reg  [0:QW];

    logic               dv_valid_next [0:QW];
    logic [NUMW-1:0]    dvx_num_next  [0:QW];
    logic [NUMW-1:0]    dvy_num_next  [0:QW];
    logic [REMW-1:0]    dvx_rem_next  [0:QW];
    logic [REMW-1:0]    dvy_rem_next  [0:QW];
    logic [NUMW-1:0]    dvx_quo_next  [0:QW];
    logic [NUMW-1:0]    dvy_quo_next  [0:QW];
    logic [DENW-1:0]    dv_den_next   [0:QW];
    ctp_pkg::div_side_t dv_side_next  [0:QW];

    always_comb
    begin
        logic [REMW:0] cand_x;
        logic [REMW:0] cand_y;
        logic [REMW:0] den_ext;
        dv_valid_next[0] = s7_valid_reg;
        dvx_num_next[0]  = {s7_ax_reg, 1'b0} + NUMW'({s7_dabs_reg, 1'b0});
        dvy_num_next[0]  = {s7_ay_reg, 1'b0} + NUMW'({s7_dabs_reg, 1'b0});
        dvx_rem_next[0]  = '0;
        dvy_rem_next[0]  = '0;
        dvx_quo_next[0]  = '0;
        dvy_quo_next[0]  = '0;
        dv_den_next[0]   = {s7_dabs_reg, 2'b00};
        dv_side_next[0]  = s7_side_reg;
        for (int k = 1; k <= QW; k++)
        begin
            den_ext          = {1'b0, dv_den_reg[k-1]};
            cand_x           = {dvx_rem_reg[k-1], dvx_num_reg[k-1][NUMW-1]};
            cand_y           = {dvy_rem_reg[k-1], dvy_num_reg[k-1][NUMW-1]};
            dv_valid_next[k] = dv_valid_reg[k-1];
            dv_den_next[k]   = dv_den_reg[k-1];
            dv_side_next[k]  = dv_side_reg[k-1];
            dvx_num_next[k]  = {dvx_num_reg[k-1][NUMW-2:0], 1'b0};
            dvy_num_next[k]  = {dvy_num_reg[k-1][NUMW-2:0], 1'b0};
            if (cand_x >= den_ext)
            begin
                dvx_rem_next[k] = REMW'(cand_x - den_ext);
                dvx_quo_next[k] = {dvx_quo_reg[k-1][NUMW-2:0], 1'b1};
            end
            else
            begin
                dvx_rem_next[k] = REMW'(cand_x);
                dvx_quo_next[k] = {dvx_quo_reg[k-1][NUMW-2:0], 1'b0};
            end
            if (cand_y >= den_ext)
            begin
                dvy_rem_next[k] = REMW'(cand_y - den_ext);
                dvy_quo_next[k] = {dvy_quo_reg[k-1][NUMW-2:0], 1'b1};
            end
            else
            begin
                dvy_rem_next[k] = REMW'(cand_y);
                dvy_quo_next[k] = {dvy_quo_reg[k-1][NUMW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                dv_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k <= QW; k++)
                dv_valid_reg[k] <= dv_valid_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                dvx_num_reg[k] <= dvx_num_next[k];
                dvy_num_reg[k] <= dvy_num_next[k];
                dvx_rem_reg[k] <= dvx_rem_next[k];
                dvy_rem_reg[k] <= dvy_rem_next[k];
                dvx_quo_reg[k] <= dvx_quo_next[k];
                dvy_quo_reg[k] <= dvy_quo_next[k];
                dv_den_reg[k]  <= dv_den_next[k];
                dv_side_reg[k] <= dv_side_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // P1: signed centre offsets, magnitudes for the radius
    // ------------------------------------------------------------------
    logic                 p1_valid_reg;
    logic signed [OW-1:0] p1_ox_reg, p1_oy_reg;
    logic [MAGW-1:0]      p1_mx_reg, p1_my_reg;
    logic                 p1_big_reg;
    ctp_pkg::div_side_t   p1_side_reg;
    logic [NUMW-1:0]      qx, qy;

    assign qx = dvx_quo_reg[QW];
    assign qy = dvy_quo_reg[QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= dv_valid_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_ox_reg   <= dv_side_reg[QW].negx ? OW'(0) - {1'b0, qx} : {1'b0, qx};
            p1_oy_reg   <= dv_side_reg[QW].negy ? OW'(0) - {1'b0, qy} : {1'b0, qy};
            p1_mx_reg   <= qx[MAGW-1:0];
            p1_my_reg   <= qy[MAGW-1:0];
            p1_big_reg  <= (qx[NUMW-1:MAGW] != '0) || (qy[NUMW-1:MAGW] != '0);
            p1_side_reg <= dv_side_reg[QW];
        end
    end

    // ------------------------------------------------------------------
    // P2: absolute centre with saturation, squared offsets
    // ------------------------------------------------------------------
    logic                  p2_valid_reg;
    logic [RESW-1:0]       p2_cx_reg, p2_cy_reg;
    logic [2*MAGW-1:0]     p2_sqx_reg, p2_sqy_reg;
    logic                  p2_big_reg;
    logic                  p2_ok_reg;
    logic signed [CXW-1:0] p1_cx, p1_cy;

    assign p1_cx = {p1_ox_reg[OW-1], p1_ox_reg}
                 + {{(CXW-CW){p1_side_reg.x0[CW-1]}}, p1_side_reg.x0};
    assign p1_cy = {p1_oy_reg[OW-1], p1_oy_reg}
                 + {{(CXW-CW){p1_side_reg.y0[CW-1]}}, p1_side_reg.y0};

    function automatic logic [RESW-1:0] sat_res(input logic [CXW-1:0] v);
        logic fits;
        fits = (v[CXW-1:RESW-1] == '0) || (v[CXW-1:RESW-1] == '1);
        if (fits)
            sat_res = v[RESW-1:0];
        else if (v[CXW-1])
            sat_res = {1'b1, {(RESW-1){1'b0}}};
        else
            sat_res = {1'b0, {(RESW-1){1'b1}}};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_cx_reg  <= sat_res(p1_cx);
            p2_cy_reg  <= sat_res(p1_cy);
            p2_sqx_reg <= p1_mx_reg * p1_mx_reg;
            p2_sqy_reg <= p1_my_reg * p1_my_reg;
            p2_big_reg <= p1_big_reg;
            p2_ok_reg  <= p1_side_reg.ok;
        end
    end

    // ------------------------------------------------------------------
    // Square root: stage 0 loads the squared radius, then one root bit
    // per stage from two operand bits
    // ------------------------------------------------------------------
    logic                sq_valid_reg [0:ROOTW];
    logic [SQW-1:0]      sq_num_reg   [0:ROOTW];
    logic [SRW-1:0]      sq_rem_reg   [0:ROOTW];
    logic [ROOTW-1:0]    sq_root_reg  [0:ROOTW];
    ctp_pkg::sqrt_side_t sq_side_reg  [0:ROOTW];

    logic                sq_valid_next [0:ROOTW];
    logic [SQW-1:0]      sq_num_next   [0:ROOTW];
    logic [SRW-1:0]      sq_rem_next   [0:ROOTW];
    logic [ROOTW-1:0]    sq_root_next  [0:ROOTW];
    ctp_pkg::sqrt_side_t sq_side_next  [0:ROOTW];

    always_comb
    begin
        logic [SRW+1:0] cand;
        logic [SRW+1:0] trial;
        sq_valid_next[0]    = p2_valid_reg;
        sq_num_next[0]      = SQW'(p2_sqx_reg) + SQW'(p2_sqy_reg);
        sq_rem_next[0]      = '0;
        sq_root_next[0]     = '0;
        sq_side_next[0].ok  = p2_ok_reg;
        sq_side_next[0].big = p2_big_reg;
        sq_side_next[0].cx  = p2_cx_reg;
        sq_side_next[0].cy  = p2_cy_reg;
        for (int k = 1; k <= ROOTW; k++)
        begin
            cand             = {sq_rem_reg[k-1], sq_num_reg[k-1][SQW-1:SQW-2]};
            trial            = {2'b00, sq_root_reg[k-1], 2'b01};
            sq_valid_next[k] = sq_valid_reg[k-1];
            sq_side_next[k]  = sq_side_reg[k-1];
            sq_num_next[k]   = {sq_num_reg[k-1][SQW-3:0], 2'b00};
            if (cand >= trial)
            begin
                sq_rem_next[k]  = SRW'(cand - trial);
                sq_root_next[k] = {sq_root_reg[k-1][ROOTW-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = SRW'(cand);
                sq_root_next[k] = {sq_root_reg[k-1][ROOTW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOTW; k++)
                sq_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k <= ROOTW; k++)
                sq_valid_reg[k] <= sq_valid_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= ROOTW; k++)
            begin
                sq_num_reg[k]  <= sq_num_next[k];
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
                sq_side_reg[k] <= sq_side_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result assembly: degenerate triples give all zero fields
    // ------------------------------------------------------------------
    ctp_pkg::circle_t    res;
    ctp_pkg::sqrt_side_t last_side;
    logic [ROOTW-1:0]    last_root;

    assign last_side = sq_side_reg[ROOTW];
    assign last_root = sq_root_reg[ROOTW];

    always_comb
    begin
        res.circle_valid = last_side.ok;
        res.centre_x     = last_side.ok ? last_side.cx : '0;
        res.centre_y     = last_side.ok ? last_side.cy : '0;
        if (!last_side.ok)
            res.radius = '0;
        else if (last_side.big || (last_root[ROOTW-1:RESW] != '0))
            res.radius = '1;
        else
            res.radius = last_root[RESW-1:0];
    end

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    ctp_pkg::circle_t out_data_reg;
    ctp_pkg::circle_t skid_data_reg;
    logic             new_res;
    logic             out_load_new;
    logic             out_load_skid;
    logic             skid_load;

    assign new_res       = en && sq_valid_reg[ROOTW];
    assign skid_load     = new_res && out_valid_reg && circ_stall;
    assign out_load_new  = new_res && !(out_valid_reg && circ_stall);
    assign out_load_skid = skid_valid_reg && !circ_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load_new || out_load_skid)
                out_valid_reg <= 1'b1;
            else if (!circ_stall)
                out_valid_reg <= 1'b0;
            if (skid_load)
                skid_valid_reg <= 1'b1;
            else if (out_load_skid)
                skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
            out_data_reg <= skid_data_reg;
        else if (out_load_new)
            out_data_reg <= res;
        if (skid_load)
            skid_data_reg <= res;
    end

    assign circ_valid = out_valid_reg;
    assign circ       = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(circ_stall))
        else $error("skid filled without an output stall");

    a_frozen_tail: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |=> $stable(sq_valid_reg[ROOTW]))
        else $error("pipeline moved while frozen");

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (circ_valid && !circ.circle_valid) |->
            (circ.centre_x == '0 && circ.centre_y == '0 && circ.radius == '0))
        else $error("degenerate triple with nonzero result fields");

endmodule

`default_nettype wire

// ----- tb/circle_through_three_points_top_tb.sv -----
// ----------------------------------------------------------------------------
// circle_through_three_points_top_tb - circumcircle block testbench
// Drives point triples with random gaps, stalls the result side at random, and
// checks each circle against an exact integer predictor kept in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module circle_through_three_points_top_tb;

    localparam int N_RANDOM = 1250;

    // --------------------------------------------------------------------
    // Circle predictor and store of expected circles
    // --------------------------------------------------------------------
    class circle_scoreboard;
        ctp_pkg::circle_t pending[$];
        int               errors;

        function new();
            errors = 0;
        endfunction

        // sign-magnitude rounding division, ties away from zero
        static function logic signed [255:0] round_div(logic signed [255:0] n,
                                                       logic signed [255:0] m);
            logic signed [255:0] a;
            logic signed [255:0] b;
            logic signed [255:0] q;
            a = (n < 0) ? -n : n;
            b = (m < 0) ? -m : m;
            q = (2 * a + b) / (2 * b);
            return ((n < 0) != (m < 0)) ? -q : q;
        endfunction

        static function logic [31:0] sat32(logic signed [255:0] v);
            if (v > 64'sh7FFFFFFF)
                return 32'h7FFFFFFF;
            if (v < -64'sh80000000)
                return 32'h80000000;
            return v[31:0];
        endfunction

        static function logic [34:0] floor_sqrt(logic [127:0] n);
            logic [34:0] r;
            logic [34:0] c;
            r = '0;
            for (int i = 34; i >= 0; i--)
            begin
                c = r | (35'd1 << i);
                if ({93'd0, c} * {93'd0, c} <= n)
                    r = c;
            end
            return r;
        endfunction

        static function ctp_pkg::circle_t circumcircle(ctp_pkg::points_t p);
            logic signed [255:0] x0, y0, u1, v1, u2, v2, d, s1, s2, nx, ny, ox, oy;
            logic [127:0]        ax, ay;
            logic [34:0]         rt;
            ctp_pkg::circle_t    c;
            c  = '0;
            x0 = 256'(p.first_x);
            y0 = 256'(p.first_y);
            u1 = p.middle_x - x0;
            v1 = p.middle_y - y0;
            u2 = p.last_x - x0;
            v2 = p.last_y - y0;
            d  = u1 * v2 - u2 * v1;
            if (d == 0)
                return c;
            s1 = u1 * u1 + v1 * v1;
            s2 = u2 * u2 + v2 * v2;
            nx = v2 * s1 - v1 * s2;
            ny = u1 * s2 - u2 * s1;
            ox = round_div(nx, 2 * d);
            oy = round_div(ny, 2 * d);
            c.circle_valid = 1'b1;
            c.centre_x = sat32(ox + x0);
            c.centre_y = sat32(oy + y0);
            ax = 128'((ox < 0) ? -ox : ox);
            ay = 128'((oy < 0) ? -oy : oy);
            if (ax < (128'd1 << 33) && ay < (128'd1 << 33))
            begin
                rt = floor_sqrt(ax * ax + ay * ay);
                c.radius = (rt > 35'hFFFFFFFF) ? 32'hFFFFFFFF : rt[31:0];
            end
            else
                c.radius = 32'hFFFFFFFF;
            return c;
        endfunction

        function void note_points(ctp_pkg::points_t p);
            pending.insert(pending.size(), circumcircle(p));
        endfunction

        task check_circle(ctp_pkg::circle_t got);
            ctp_pkg::circle_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("circle with no triple outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.circle_valid !== want.circle_valid)
                report_mismatch($sformatf("circle_valid got %0b want %0b",
                                          got.circle_valid, want.circle_valid));
            if (got.centre_x !== want.centre_x)
                report_mismatch($sformatf("centre_x got %0d want %0d",
                                          got.centre_x, want.centre_x));
            if (got.centre_y !== want.centre_y)
                report_mismatch($sformatf("centre_y got %0d want %0d",
                                          got.centre_y, want.centre_y));
            if (got.radius !== want.radius)
                report_mismatch($sformatf("radius got %0d want %0d",
                                          got.radius, want.radius));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             pts_valid;
    logic             pts_stall;
    ctp_pkg::points_t pts;
    logic             circ_valid;
    logic             circ_stall;
    ctp_pkg::circle_t circ;

    circle_scoreboard sb;
    bit               sink_busy;
    int               hold_left;

    circle_through_three_points_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pts_valid  (pts_valid),
        .pts_stall  (pts_stall),
        .pts        (pts),
        .circ_valid (circ_valid),
        .circ_stall (circ_stall),
        .circ       (circ)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // mostly short gaps, now and then a long one, sometimes none at all
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'(24'h800000 + $urandom_range(0, 3));
            1: return 24'(24'h7FFFFF - $urandom_range(0, 3));
            2: return 24'($urandom_range(0, 15) - 8);
            3: return 24'($urandom_range(0, 2047) - 1024);
            default: return 24'($urandom);
        endcase
    endfunction

    // mostly proper triangles; some collinear, coincident and near-degenerate
    function automatic ctp_pkg::points_t rand_points();
        ctp_pkg::points_t   p;
        logic signed [23:0] dx, dy;
        int k;
        p.first_x  = rand_coord();
        p.first_y  = rand_coord();
        p.middle_x = rand_coord();
        p.middle_y = rand_coord();
        p.last_x   = rand_coord();
        p.last_y   = rand_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                dx = 24'($urandom_range(0, 255) - 128);
                dy = 24'($urandom_range(0, 255) - 128);
                k  = $urandom_range(0, 40) - 20;
                p.middle_x = p.first_x + dx;
                p.middle_y = p.first_y + dy;
                p.last_x   = 24'(p.first_x + k * dx);
                p.last_y   = 24'(p.first_y + k * dy);
            end
            1:
            begin
                p.last_x = p.first_x;
                p.last_y = p.first_y;
            end
            2:
            begin
                // almost collinear: very large centre
                p.middle_x = 24'(p.first_x + 1000);
                p.middle_y = p.first_y;
                p.last_x   = 24'(p.first_x + 2000 + ($urandom_range(0, 1) ? 0 : 5000));
                p.last_y   = 24'(p.first_y + ($urandom_range(0, 1) ? 1 : -1));
            end
            default: ;
        endcase
        return p;
    endfunction

    // valid stays high between back-to-back transactions
    task automatic send_points(ctp_pkg::points_t p);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            pts_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pts_valid <= 1'b1;
        pts       <= p;
        @(posedge clk);
        while (pts_stall)
            @(posedge clk);
        sb.note_points(p);
    endtask

    task automatic send_corner(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                               logic [23:0] d, logic [23:0] e, logic [23:0] f);
        ctp_pkg::points_t p;
        p = {a, b, c, d, e, f};
        send_points(p);
    endtask

    // result side: sample at the edge, stall pattern changes after it
    always @(posedge clk)
    begin
        if (rst_n && circ_valid && !circ_stall)
            sb.check_circle(circ);
        if (!sink_busy)
            circ_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            circ_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 1)
        begin
            hold_left = $urandom_range(10, 60);
            circ_stall <= 1'b1;
        end
        else
            circ_stall <= ($urandom_range(0, 99) < 35) ? 1'b1 : 1'b0;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        pts_valid  = 1'b0;
        pts        = '0;
        circ_stall = 1'b0;
        sink_busy  = 1'b0;
        hold_left  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: right angles, extremes, collinear, coincident, saturation
        send_corner(24'd0, 24'd0, 24'd256, 24'd0, 24'd0, 24'd256);
        send_corner(24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd1);
        send_corner(24'd5, 24'd5, 24'd5, 24'd5, 24'd5, 24'd5);
        send_corner(24'd0, 24'd0, 24'd10, 24'd10, 24'd20, 24'd20);
        send_corner(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
                    24'h800000, 24'h7FFFFF);
        send_corner(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                    24'h7FFFFF, 24'h800000);
        send_corner(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                    24'h800000, 24'h800000);
        send_corner(24'h800000, 24'd0, 24'd0, 24'd1, 24'h7FFFFF, 24'd0);
        send_corner(24'h800000, 24'd0, 24'd0, 24'd0, 24'h7FFFFF, 24'd1);
        send_corner(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                    24'h7FFFFF, 24'h7FFFFE);
        send_corner(24'd0, 24'd0, 24'd1, 24'd0, 24'd2, 24'd1);
        send_corner(24'd0, 24'd0, 24'd3, 24'd0, 24'd1, 24'd1);
        send_corner(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFF,
                    24'hFFFFFF, 24'hFFFFFE);
        send_corner(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
                    24'h000000, 24'h7FFFFF);
        send_corner(24'd0, 24'd0, 24'd0, 24'd0, 24'd7, 24'd3);

        // random, with result stalls enabled except for transactions 600 to 799
        sink_busy = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 600)
                sink_busy = 1'b0;
            if (i == 800)
                sink_busy = 1'b1;
            send_points(rand_points());
        end
        pts_valid <= 1'b0;

        sink_busy = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
